>>> rtl/kdc_pkg.sv
// ----------------------------------------------------------------------------
// kdc_pkg
// Types and constants shared by the key debounce, click and long-press core.
// ----------------------------------------------------------------------------
package kdc_pkg;

  localparam int unsigned CNT_W  = 8;
  localparam int unsigned TICK_W = 32;

  // Register map, indexed by cfg_paddr[2]
  typedef logic reg_idx_t;
  localparam reg_idx_t REG_DEBOUNCE   = 1'b0;
  localparam reg_idx_t REG_LONG_PRESS = 1'b1;

  localparam logic [CNT_W-1:0]  DEBOUNCE_RESET   = 8'd3;
  localparam logic [TICK_W-1:0] LONG_PRESS_RESET = 32'd100;

  // Event queue depth: room for two events per item plus slack
  localparam int unsigned EVQ_DEPTH = 4;

  typedef enum logic [1:0] {
    EV_DOWN  = 2'd0,
    EV_UP    = 2'd1,
    EV_CLICK = 2'd2,
    EV_LONG  = 2'd3
  } ev_kind_t;

  typedef struct packed {
    logic              seeded;
    logic              stable;
    logic              cand;
    logic [CNT_W-1:0]  cnt;
    logic              started;
    logic              long_sent;
    logic [TICK_W-1:0] tick;
  } key_state_t;

  // Events caused by one sample: count (0..2) and kinds in order
  typedef struct packed {
    logic [1:0] num;
    ev_kind_t   k0;
    ev_kind_t   k1;
  } ev_pair_t;

  typedef struct packed {
    logic     key;
    ev_kind_t kind;
    logic     last;
  } ev_t;

endpackage

>>> rtl/kdc_key_eval.sv
// ----------------------------------------------------------------------------
// kdc_key_eval
// Debounce and press-sequence update for one sample of one key.
// ----------------------------------------------------------------------------
module kdc_key_eval (
  input  kdc_pkg::key_state_t               st,
  input  logic                              act,
  input  logic [kdc_pkg::TICK_W-1:0]        now,
  input  logic [kdc_pkg::CNT_W-1:0]         db_cnt,
  input  logic [kdc_pkg::TICK_W-1:0]        lp_ticks,
  output kdc_pkg::key_state_t               st_nxt,
  output kdc_pkg::ev_pair_t                 ev
);

  logic                       cand_n;
  logic [kdc_pkg::CNT_W-1:0]  cnt_n;
  logic                       change;
  logic                       down;
  logic                       up;
  logic                       click;
  logic                       long_ev;
  logic                       stable_n;
  logic                       started_n;
  logic                       long_mid;
  logic [kdc_pkg::TICK_W-1:0] tick_n;
  logic [kdc_pkg::TICK_W-1:0] held;

  always_comb begin
    // restart the count on a disagreeing sample, else saturate at threshold
    if (act != st.cand) begin
      cand_n = act;
      cnt_n  = kdc_pkg::CNT_W'(1);
    end else if (st.cnt < db_cnt) begin
      cand_n = st.cand;
      cnt_n  = st.cnt + kdc_pkg::CNT_W'(1);
    end else begin
      cand_n = st.cand;
      cnt_n  = st.cnt;
    end

    change    = (cnt_n >= db_cnt) && (st.stable != cand_n);
    stable_n  = change ? cand_n : st.stable;
    down      = change && cand_n;
    up        = change && !cand_n && st.started;
    click     = up && !st.long_sent;
    tick_n    = down ? now : st.tick;
    started_n = down ? 1'b1 : (up ? 1'b0 : st.started);
    long_mid  = down ? 1'b0 : st.long_sent;

    // tick difference wraps modulo 2^32
    held    = now - tick_n;
    long_ev = stable_n && started_n && !long_mid && (held >= lp_ticks);
  end

  always_comb begin
    st_nxt = st;
    ev     = '{num: 2'd0, k0: kdc_pkg::EV_DOWN, k1: kdc_pkg::EV_LONG};
    if (!st.seeded) begin
      // first sample only seeds the levels and the tick
      st_nxt.seeded  = 1'b1;
      st_nxt.stable  = act;
      st_nxt.cand    = act;
      st_nxt.tick    = now;
      st_nxt.started = 1'b0;
    end else begin
      st_nxt.cand      = cand_n;
      st_nxt.cnt       = cnt_n;
      st_nxt.stable    = stable_n;
      st_nxt.started   = started_n;
      st_nxt.tick      = tick_n;
      st_nxt.long_sent = long_mid | long_ev;

      if (down) begin
        ev.k0  = kdc_pkg::EV_DOWN;
        ev.k1  = kdc_pkg::EV_LONG;
        ev.num = long_ev ? 2'd2 : 2'd1;
      end else if (up) begin
        ev.k0  = kdc_pkg::EV_UP;
        ev.k1  = kdc_pkg::EV_CLICK;
        ev.num = click ? 2'd2 : 2'd1;
      end else if (long_ev) begin
        ev.k0  = kdc_pkg::EV_LONG;
        ev.num = 2'd1;
      end
    end
  end

endmodule

>>> rtl/kdc_evq.sv
// ----------------------------------------------------------------------------
// kdc_evq
// Small event queue: takes up to two events per cycle, gives one per cycle while head_ready is high.
// ----------------------------------------------------------------------------
module kdc_evq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_num,
  input  kdc_pkg::ev_t  push0,
  input  kdc_pkg::ev_t  push1,
  output logic          room2,
  output logic          head_valid,
  input  logic          head_ready,
  output kdc_pkg::ev_t  head
);

  localparam int unsigned PW = $clog2(kdc_pkg::EVQ_DEPTH);
  localparam int unsigned CW = $clog2(kdc_pkg::EVQ_DEPTH + 1);

  kdc_pkg::ev_t    mem_r [kdc_pkg::EVQ_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW-1:0]   rd_ptr_nxt;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;
  logic            pop;

  assign pop        = head_valid && head_ready;
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign room2      = (count_r <= CW'(kdc_pkg::EVQ_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push_num);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    count_nxt  = count_r + CW'(push_num) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_num != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_num == 2'd2) begin
      mem_r[wr_ptr_r + PW'(1)] <= push1;
    end
  end

endmodule

>>> rtl/key_debounce_click_long_press_core.sv
// ----------------------------------------------------------------------------
// key_debounce_click_long_press_core
// An accepted item is held in the input register and evaluated there; its
// events are then written into the event queue, which drives out_*.
// Throughput: one item per cycle; an item with two events (DOWN plus
// LONG_PRESS, UP plus CLICK) leaves as two output transfers, and the input
// stalls while the event queue has fewer than two free slots.
// Reset (rst_n low, synchronous) clears all key state, empties the queue and
// loads the register defaults.
// ----------------------------------------------------------------------------
module key_debounce_click_long_press_core #(
  parameter int unsigned NUM_KEYS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // input item stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [0] key_index, [1] level_active, [33:2] now_tick
  // event stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] event_key
  output logic [1:0]  out_tuser,  // [1:0] event_kind
  output logic        out_tlast,  // last_of_run
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  // configuration registers
  logic [kdc_pkg::CNT_W-1:0]  db_cnt_r;
  logic [kdc_pkg::TICK_W-1:0] lp_ticks_r;
  logic                       cfg_wr;
  kdc_pkg::reg_idx_t          cfg_sel;

  // input register
  logic                       in_vld_r;
  logic                       key_r;
  logic                       act_r;
  logic [kdc_pkg::TICK_W-1:0] now_r;

  kdc_pkg::key_state_t        key_st_r [NUM_KEYS];
  kdc_pkg::key_state_t        st_cur;
  kdc_pkg::key_state_t        st_nxt;
  kdc_pkg::ev_pair_t          ev;
  logic                       in_range;
  logic [KW-1:0]              idx;
  logic                       fire;
  logic                       room2;
  logic [1:0]                 push_num;
  kdc_pkg::ev_t               push0;
  kdc_pkg::ev_t               push1;
  kdc_pkg::ev_t               head;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = cfg_paddr[2];

  always_comb begin
    unique case (cfg_sel)
      kdc_pkg::REG_DEBOUNCE:   cfg_prdata = 32'(db_cnt_r);
      kdc_pkg::REG_LONG_PRESS: cfg_prdata = lp_ticks_r;
      default:                 cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_cnt_r   <= kdc_pkg::DEBOUNCE_RESET;
      lp_ticks_r <= kdc_pkg::LONG_PRESS_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        kdc_pkg::REG_DEBOUNCE:   db_cnt_r   <= cfg_pwdata[kdc_pkg::CNT_W-1:0];
        kdc_pkg::REG_LONG_PRESS: lp_ticks_r <= cfg_pwdata;
        default:                 ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input
  assign fire      = in_vld_r && room2;
  assign in_tready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      key_r <= in_tdata[0];
      act_r <= in_tdata[1];
      now_r <= in_tdata[33:2];
    end
  end

  // ---------------------------------------------------------------- evaluate
  assign in_range = (32'(key_r) < NUM_KEYS);
  assign idx      = in_range ? KW'(key_r) : '0;
  assign st_cur   = key_st_r[idx];

  kdc_key_eval u_eval (
    .st       (st_cur),
    .act      (act_r),
    .now      (now_r),
    .db_cnt   (db_cnt_r),
    .lp_ticks (lp_ticks_r),
    .st_nxt   (st_nxt),
    .ev       (ev)
  );

  // state is written at the end of the evaluate cycle, so the next item
  // in the input register already sees it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        key_st_r[i] <= '0;
      end
    end else if (fire && in_range) begin
      key_st_r[idx] <= st_nxt;
    end
  end

  assign push_num = (fire && in_range) ? ev.num : 2'd0;
  assign push0    = '{key: key_r, kind: ev.k0, last: (ev.num == 2'd1)};
  assign push1    = '{key: key_r, kind: ev.k1, last: 1'b1};

  kdc_evq u_evq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_num   (push_num),
    .push0      (push0),
    .push1      (push1),
    .room2      (room2),
    .head_valid (out_tvalid),
    .head_ready (out_tready),
    .head       (head)
  );

  assign out_tdata = {7'd0, head.key};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

>>> rtl/kdc_checker.sv
// ----------------------------------------------------------------------------
// kdc_checker
// Port-level checks on the key debounce core, bound to its top level.
// ----------------------------------------------------------------------------
module kdc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast,
  input logic        cfg_psel,
  input logic        cfg_pready
);

  // hold a stalled event
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("event payload changed while stalled");

  // reset empties the event queue
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("event pending right after reset");

  // CLICK and LONG_PRESS always close the run of their sample
  a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == kdc_pkg::EV_CLICK || out_tuser == kdc_pkg::EV_LONG)
      |-> out_tlast)
    else $error("CLICK or LONG_PRESS without last_of_run");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel |-> cfg_pready)
    else $error("configuration port not ready");

endmodule

bind key_debounce_click_long_press_core kdc_checker u_kdc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .out_tuser   (out_tuser),
  .out_tlast   (out_tlast),
  .cfg_psel    (cfg_psel),
  .cfg_pready  (cfg_pready)
);
